### design/ddf_pkg.sv
// Shared types and constants for the decimal digit formatter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ddf_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int DIGIT_W    = 4;
    localparam int CODE_W     = 6;

    // A 32-bit value needs ten decimal digits; the converter keeps enough for both.
    localparam int VALUE_DIGITS = 10;
    localparam int BCD_DIGITS   = (MAX_DIGITS > VALUE_DIGITS) ? MAX_DIGITS : VALUE_DIGITS;
    localparam int BCD_W        = BCD_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W    = $clog2(VALUE_W);
    localparam int IDX_W        = $clog2(BCD_DIGITS + 1);

    localparam logic [CODE_W-1:0] CODE_SPACE = CODE_W'(8'h20);
    localparam logic [CODE_W-1:0] CODE_ZERO  = CODE_W'(8'h30);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digit_count;
        logic               mode;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              last;
        logic              overflow;
    } t_out_item;

    // Finished conversion handed from the converter to the emitter.
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [COUNT_W-1:0] digit_count;
        logic               mode;
    } t_conv_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_HOLD
    } t_conv_state;

endpackage

### design/decimal_digit_formatter.sv
// Top level of the decimal digit formatter: converter followed by character emitter.
// Depends on ddf_pkg, ddf_bcd_conv and ddf_char_emit.
//
//  Port group   Direction  Handshake              Payload
//  in           input      i_in_valid/o_in_ready  i_in_item  (value, digit_count, mode)
//  out          output     o_out_valid/i_out_ready o_out_item (char_code, last, overflow)
//
// Conversion shifts one value bit per cycle through the BCD shift register.
// Characters then go out one at a time, held while the output stalls; a new value is
// converted while the previous one's characters go out.
// Reset is synchronous and active low and empties both stages.
// A stall on the output holds the current character and, once its digits run out,
// the finished conversion waits in the converter.
`timescale 1ns / 1ps

module decimal_digit_formatter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ddf_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ddf_pkg::t_out_item o_out_item
);
    import ddf_pkg::*;

    logic      w_res_valid;
    logic      w_res_ready;
    t_conv_res w_res;

    ddf_bcd_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    ddf_char_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .o_res_ready (w_res_ready),
        .i_res       (w_res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### design/ddf_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-three).
// Depends on ddf_pkg for the item and result types.
`timescale 1ns / 1ps

module ddf_bcd_conv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ddf_pkg::t_in_item  i_in_item,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output ddf_pkg::t_conv_res o_res
);
    import ddf_pkg::*;

    t_conv_state r_state, n_state;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [VALUE_W-1:0]   r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_mode;
    logic [BCD_W-1:0]     w_adj;
    logic                 w_shift;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SHIFT;
            S_SHIFT: if (r_bit == BIT_CNT_W'(VALUE_W - 1)) n_state = S_HOLD;
            S_HOLD:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        w_shift     = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready  = 1'b1;
            S_SHIFT: w_shift     = 1'b1;
            S_HOLD:  o_res_valid = 1'b1;
            default: o_in_ready  = 1'b0;
        endcase
    end

    // Each BCD digit of five or more gets three added before the next shift.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                w_adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                w_adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            if (o_in_ready && i_in_valid)
                r_bit <= '0;
            else if (w_shift)
                r_bit <= r_bit + BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_bin   <= i_in_item.value;
            r_bcd   <= '0;
            r_count <= i_in_item.digit_count;
            r_mode  <= i_in_item.mode;
        end else if (w_shift) begin
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
        end
    end

    assign o_res.bcd         = r_bcd;
    assign o_res.digit_count = r_count;
    assign o_res.mode        = r_mode;

endmodule

### design/ddf_char_emit.sv
// Digit shift register that sends one display character per transfer.
// Depends on ddf_pkg for the conversion and output item types.
`timescale 1ns / 1ps

module ddf_char_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    output logic               o_res_ready,
    input  ddf_pkg::t_conv_res i_res,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ddf_pkg::t_out_item o_out_item
);
    import ddf_pkg::*;

    logic [BCD_W-1:0]   r_sr;
    logic [IDX_W-1:0]   r_rem;
    logic               r_ovf;
    logic               r_blank;
    logic               r_leading;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [IDX_W-1:0]   w_cnt;
    logic [IDX_W-1:0]   w_sh;
    logic               w_ovf;
    logic               w_load;
    logic               w_adv;
    logic [DIGIT_W-1:0] w_digit;
    logic               w_lead;
    logic               w_last;
    logic [CODE_W-1:0]  w_code;

    assign o_res_ready = (r_rem == '0);
    assign w_load      = o_res_ready && i_res_valid;

    // Count of zero shows one character; counts beyond the maximum saturate.
    always_comb begin
        if (i_res.digit_count == '0)
            w_cnt = IDX_W'(1);
        else if (int'(i_res.digit_count) > MAX_DIGITS)
            w_cnt = IDX_W'(MAX_DIGITS);
        else
            w_cnt = IDX_W'(i_res.digit_count);
        w_sh = IDX_W'(BCD_DIGITS) - w_cnt;
    end

    // Any non-zero digit above the shown positions means the value did not fit.
    always_comb begin
        w_ovf = 1'b0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (IDX_W'(i) >= w_cnt && i_res.bcd[i*DIGIT_W +: DIGIT_W] != '0)
                w_ovf = 1'b1;
        end
    end

    assign w_adv   = (r_rem != '0) && (!r_out_valid || i_out_ready);
    assign w_digit = r_sr[BCD_W-1 -: DIGIT_W];
    assign w_lead  = r_leading && (w_digit == '0);
    assign w_last  = (r_rem == IDX_W'(1));

    always_comb begin
        if (r_blank && w_lead && !w_last)
            w_code = CODE_SPACE;
        else
            w_code = CODE_ZERO + CODE_W'(w_digit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load)
                r_rem <= w_cnt;
            else if (w_adv)
                r_rem <= r_rem - IDX_W'(1);
            if (w_adv)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            // Left-align so the most significant shown digit sits at the top.
            r_sr      <= i_res.bcd << (w_sh * DIGIT_W);
            r_ovf     <= w_ovf;
            r_blank   <= i_res.mode;
            r_leading <= 1'b1;
        end else if (w_adv) begin
            r_sr      <= {r_sr[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            r_leading <= w_lead;
        end
        if (w_adv) begin
            r_out.char_code <= w_code;
            r_out.last      <= w_last;
            r_out.overflow  <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### tb/tb.sv
// Self-checking testbench for decimal_digit_formatter: drives numbers, counts and modes,
// predicts every display character and compares each output transfer with it.
// Depends on ddf_pkg and the decimal_digit_formatter RTL.
`timescale 1ns / 1ps

module tb;
    import ddf_pkg::*;

    localparam int          TAIL_CYCLES  = 80;
    localparam int          STALL_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    t_out_item   expected_chars[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned tx_idle_pct    = 27;
    int unsigned rx_idle_pct    = 54;
    int unsigned stall_left     = 0;
    bit          stall_req      = 1'b0;

    decimal_digit_formatter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("decimal_digit_formatter regression: fail");
            $finish;
        end
    end

    // The receiver either follows its idle rate or, on request, holds off for a long stretch.
    always @(posedge i_clk) begin
        if (stall_req) begin
            stall_req  = 1'b0;
            stall_left = STALL_CYCLES;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Works out the characters of one number, most significant position first.
    function automatic void predict_characters(input t_in_item item);
        logic [3:0]         digit[MAX_DIGITS];
        logic [VALUE_W-1:0] rest;
        logic               ovf;
        logic               shown;
        int                 n;
        int                 i;
        t_out_item          ch;
        n = int'(item.digit_count);
        if (n == 0) n = 1;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        rest = item.value;
        for (i = 0; i < n; i++) begin
            digit[i] = 4'(rest % 10);
            rest     = rest / 10;
        end
        ovf   = (rest != 0);
        shown = 1'b0;
        for (i = n - 1; i >= 0; i--) begin
            shown = shown | (digit[i] != 0);
            if (item.mode && !shown && i != 0) begin
                ch.char_code = CODE_SPACE;
            end else begin
                ch.char_code = CODE_ZERO + CODE_W'(digit[i]);
            end
            ch.last     = (i == 0);
            ch.overflow = ovf;
            expected_chars.push_back(ch);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character transfer %h", o_out_item));
            end else begin
                want = expected_chars.pop_front();
                if (o_out_item.char_code !== want.char_code)
                    report_mismatch($sformatf("char_code %h, expected %h",
                                              o_out_item.char_code, want.char_code));
                if (o_out_item.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              o_out_item.last, want.last));
                if (o_out_item.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              o_out_item.overflow, want.overflow));
            end
        end
    end

    // Valid stays high from one number to the next unless the sender decides to idle.
    task automatic send_number(input logic [VALUE_W-1:0] value,
                               input logic [COUNT_W-1:0] count, input logic mode);
        t_in_item item;
        item.value       = value;
        item.digit_count = count;
        item.mode        = mode;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_characters(item);
    endtask

    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_number();
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        longint unsigned    span;
        int unsigned        sel;
        int                 n;
        int                 k;
        sel = $urandom_range(99);
        n   = $urandom_range(MAX_DIGITS, 1);
        if (sel < 5) begin
            count = '0;
            n     = 1;
        end else if (sel < 12) begin
            count = COUNT_W'($urandom_range(15, MAX_DIGITS + 1));
            n     = MAX_DIGITS;
        end else begin
            count = COUNT_W'(n);
        end
        // Mostly numbers that fit the count, so that blanking is exercised at every width.
        span = 1;
        for (k = 0; k < n; k++) span = span * 10;
        sel = $urandom_range(99);
        if (sel < 55) begin
            value = (span > 64'hFFFF_FFFF) ? $urandom : VALUE_W'($urandom % span);
        end else if (sel < 70) begin
            value = $urandom_range(999);
        end else if (sel < 90) begin
            value = $urandom;
        end else begin
            span = 1;
            for (k = $urandom_range(9); k > 0; k--) span = span * 10;
            value = VALUE_W'(span - $urandom_range(1));
        end
        send_number(value, count, 1'($urandom_range(1)));
    endtask

    task automatic test_directed_cases();
        send_number(32'd0, 4'd1, 1'b0);
        send_number(32'd0, 4'd1, 1'b1);
        send_number(32'd0, 4'd10, 1'b1);
        send_number(32'd0, 4'd10, 1'b0);
        send_number(32'hFFFF_FFFF, 4'd10, 1'b0);
        send_number(32'hFFFF_FFFF, 4'd10, 1'b1);
        send_number(32'hFFFF_FFFF, 4'd9, 1'b1);
        send_number(32'hFFFF_FFFF, 4'd15, 1'b1);
        send_number(32'd7, 4'd0, 1'b1);
        send_number(32'd73, 4'd0, 1'b0);
        send_number(32'd123456, 4'd11, 1'b0);
        send_number(32'd12345, 4'd3, 1'b1);
        send_number(32'd1000, 4'd3, 1'b1);
        send_number(32'd1005, 4'd3, 1'b1);
        send_number(32'd100, 4'd3, 1'b1);
        send_number(32'd5, 4'd10, 1'b1);
        send_number(32'd9, 4'd1, 1'b0);
        send_number(32'd10, 4'd1, 1'b1);
        send_number(32'd42, 4'd2, 1'b0);
        send_number(32'd7, 4'd4, 1'b0);
        send_number(32'd1_000_000_000, 4'd10, 1'b1);
        send_number(32'h8000_0000, 4'd8, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_random_stream(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_random_number();
        wait_until_drained();
    endtask

    // The receiver stops for a long stretch while numbers keep coming, so the input stalls.
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_req   = 1'b1;
        repeat (25) send_number($urandom, 4'd10, 1'($urandom_range(1)));
        wait_until_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_stream(27, 54, 128);
        test_random_stream(54, 27, 128);
        test_output_backpressure();
        test_random_stream(0, 0, 128);
        if (mismatch_count == 0) begin
            $display("decimal_digit_formatter regression: pass");
        end else begin
            $display("decimal_digit_formatter regression: fail");
        end
        $finish;
    end

endmodule
